FILE: design/double_hash_table_unit_macros.svh
// Assertion macros of the double hash table RTL.
// Included by double_hash_table_unit, the only module that carries concurrent assertions.
`ifndef DOUBLE_HASH_TABLE_UNIT_MACROS_SVH
`define DOUBLE_HASH_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dht_pkg.sv
// Package of the double hash table: sizes, codes, payload types and a helper function.
// Depends on nothing; every other file of the block but the macro header uses it.
`default_nettype none

package dht_pkg;

    localparam int TABLE_SIZE = 10;
    localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    localparam int VAL_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 4;

    localparam int REM_W = 4;

    // The remainders come from exact reciprocal quotients: for every 16-bit value,
    // floor(v * RECIP / 2^SH) equals floor(v / modulus).
    localparam int RECIP_W         = 17;
    localparam int PROD_W          = VAL_W + RECIP_W;
    localparam int RECIP_BASE_SH   = 20;
    localparam int RECIP_STRIDE_SH = 19;

    // Probe positions are sums of a slot (or base) and a stride, reduced modulo the table size.
    localparam int SUM_W      = 5;
    localparam int WRAP_STEPS = ((1 << SUM_W) - 1) / TABLE_SIZE;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [RECIP_W-1:0] t_recip;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_SEARCH = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    localparam t_rem MOD_BASE   = 4'd13;
    localparam t_rem MOD_STRIDE = 4'd7;

    // ceil(2^20 / 13) and ceil(2^19 / 7).
    localparam t_recip RECIP_BASE   = 17'd80660;
    localparam t_recip RECIP_STRIDE = 17'd74899;

    typedef struct packed {
        logic done;
        t_rem base;
        t_rem stride;
    } t_hash_res;

    // Reduce a small sum modulo the table size by repeated compare and subtract.
    function automatic t_slot wrap_slot(logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] y;
        y = x;
        for (int k = 0; k < WRAP_STEPS; k++) begin
            if (y >= SUM_W'(TABLE_SIZE)) begin
                y = y - SUM_W'(TABLE_SIZE);
            end
        end
        return y[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/dht_ifs.sv
// Valid/ready channel interfaces of the double hash table: command beats in, result beats out.
// Depends on dht_pkg for the payload types.
`default_nettype none

interface dht_in_if;
    logic            valid;
    logic            ready;
    dht_pkg::t_cmd   command;
    dht_pkg::t_value value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface dht_out_if;
    logic             valid;
    logic             ready;
    dht_pkg::t_status status;
    dht_pkg::t_index  slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

FILE: design/dht_hash.sv
// Remainder unit: value mod 13 and the stride 7 - (value mod 7) by reciprocal multiplication.
// Depends on dht_pkg.
`default_nettype none

module dht_hash (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire dht_pkg::t_value    i_value,
    output dht_pkg::t_hash_res      o_res
);

    logic                        r_busy;
    logic                        r_done;
    dht_pkg::t_value             r_val;
    dht_pkg::t_value             r_q13;
    dht_pkg::t_value             r_q7;
    dht_pkg::t_rem               r_r13;
    dht_pkg::t_rem               r_r7;
    logic [dht_pkg::PROD_W-1:0]  prod13;
    logic [dht_pkg::PROD_W-1:0]  prod7;
    dht_pkg::t_value             rem13;
    dht_pkg::t_value             rem7;

    // The quotients come from one multiply each and are registered; the remainders are then formed and registered.
    assign prod13 = dht_pkg::PROD_W'(i_value) * dht_pkg::PROD_W'(dht_pkg::RECIP_BASE);
    assign prod7  = dht_pkg::PROD_W'(i_value) * dht_pkg::PROD_W'(dht_pkg::RECIP_STRIDE);
    assign rem13  = r_val - r_q13 * dht_pkg::t_value'(dht_pkg::MOD_BASE);
    assign rem7   = r_val - r_q7 * dht_pkg::t_value'(dht_pkg::MOD_STRIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_q13 <= dht_pkg::t_value'(prod13 >> dht_pkg::RECIP_BASE_SH);
            r_q7  <= dht_pkg::t_value'(prod7 >> dht_pkg::RECIP_STRIDE_SH);
        end
        if (r_busy) begin
            r_r13 <= rem13[dht_pkg::REM_W-1:0];
            r_r7  <= rem7[dht_pkg::REM_W-1:0];
        end
    end

    assign o_res.done   = r_done;
    assign o_res.base   = r_r13;
    assign o_res.stride = dht_pkg::MOD_STRIDE - r_r7;

endmodule

`default_nettype wire

FILE: design/double_hash_table_unit.sv
// Double hashing open-addressing table: top level with the slot memory and the probe walk.
// Depends on dht_pkg, dht_ifs, dht_hash and double_hash_table_unit_macros.svh.
//
// Usage. Command beats arrive on i_item (command, value); one result beat per command
// leaves on o_result (status, slot_index). Insert places the value in the first empty
// slot of its double hashing probe sequence, search follows the same sequence, delete
// scans the slots in order and clears the first match. Command code 3 changes nothing
// and answers not found.
// Flow. One command is worked on at a time. After the accept, the hash unit first
// multiplies by the reciprocals of 13 and 7 and registers the quotients, then forms the
// remainders; the probe walk then issues one slot memory read per cycle and checks each
// read in the cycle after it. A walk ends at the first probe that decides, or once all
// TABLE_SIZE probes are issued and checked. The result then moves to the output
// register as soon as that register is free. Every probe goes through the single read
// port of the slot memory. Code 3 skips the hash and the walk and goes straight to
// the result. The next command is accepted at the earliest at the edge that can take
// the result.
// Reset clears all slot valid bits at once, so the table starts empty with no sweep.
// Stall. The result sits in an output register; a new command is accepted while it
// waits. If a second result is ready before the first is taken, the block holds it and
// accepts nothing further until the output register frees.
`default_nettype none
`include "double_hash_table_unit_macros.svh"

module double_hash_table_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dht_in_if.sink     i_item,
    dht_out_if.source  o_result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HASH = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    dht_pkg::t_cmd              r_cmd;
    dht_pkg::t_value            r_val;
    dht_pkg::t_slot             r_pos;
    dht_pkg::t_rem              r_stride;
    logic [dht_pkg::CNT_W-1:0]  r_iss_cnt;
    logic                       r_chk_vld;
    dht_pkg::t_slot             r_chk_pos;
    dht_pkg::t_value            r_rd_data;
    logic [dht_pkg::TABLE_SIZE-1:0] r_used;
    dht_pkg::t_value            r_mem [dht_pkg::TABLE_SIZE];
    dht_pkg::t_status           r_res_status;
    dht_pkg::t_index            r_res_slot;
    logic                       r_out_valid;
    dht_pkg::t_status           r_out_status;
    dht_pkg::t_index            r_out_slot;

    dht_pkg::t_hash_res         hash_res;
    logic                       in_acc;
    logic                       cmd_ok;
    logic                       walk;
    logic                       chk_used;
    logic                       chk_match;
    logic                       fin;
    logic                       hit;
    dht_pkg::t_status           fin_status;
    logic                       issue;
    logic                       out_free;
    logic                       ins_hit;
    logic                       del_hit;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid && i_item.ready;
    assign cmd_ok       = (i_item.command == dht_pkg::CMD_INSERT)
                       || (i_item.command == dht_pkg::CMD_SEARCH)
                       || (i_item.command == dht_pkg::CMD_DELETE);

    dht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && cmd_ok),
        .i_value (i_item.value),
        .o_res   (hash_res)
    );

    // Check stage of the walk: the slot read in the previous cycle is compared here.
    assign walk      = (r_state == S_WALK);
    assign chk_used  = r_used[r_chk_pos];
    assign chk_match = chk_used && (r_rd_data == r_val);

    always_comb begin
        fin        = 1'b0;
        hit        = 1'b0;
        fin_status = dht_pkg::ST_NOT_FOUND;
        if (walk && r_chk_vld) begin
            unique case (r_cmd)
                dht_pkg::CMD_INSERT: begin
                    if (!chk_used) begin
                        fin        = 1'b1;
                        hit        = 1'b1;
                        fin_status = dht_pkg::ST_OK;
                    end
                end
                dht_pkg::CMD_SEARCH: begin
                    if (!chk_used) begin
                        fin = 1'b1;
                    end else if (chk_match) begin
                        fin        = 1'b1;
                        hit        = 1'b1;
                        fin_status = dht_pkg::ST_OK;
                    end
                end
                dht_pkg::CMD_DELETE: begin
                    if (chk_match) begin
                        fin        = 1'b1;
                        hit        = 1'b1;
                        fin_status = dht_pkg::ST_OK;
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
        end else if (walk && (r_iss_cnt == dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE))) begin
            // Every probe was issued and checked without a decision.
            fin        = 1'b1;
            fin_status = (r_cmd == dht_pkg::CMD_INSERT) ? dht_pkg::ST_FULL
                                                        : dht_pkg::ST_NOT_FOUND;
        end
    end

    assign issue    = walk && !fin && (r_iss_cnt != dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE));
    assign ins_hit  = fin && hit && (r_cmd == dht_pkg::CMD_INSERT);
    assign del_hit  = fin && hit && (r_cmd == dht_pkg::CMD_DELETE);
    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = cmd_ok ? S_HASH : S_DONE;
                end
            end
            S_HASH: begin
                if (hash_res.done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, probe issue count, check valid, output valid and slot valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_chk_vld   <= 1'b0;
            r_iss_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_HASH) begin
                r_chk_vld <= 1'b0;
                r_iss_cnt <= '0;
            end else if (walk) begin
                r_chk_vld <= issue;
                if (issue) begin
                    r_iss_cnt <= r_iss_cnt + 1'b1;
                end
            end
            if (ins_hit) begin
                r_used[r_chk_pos] <= 1'b1;
            end else if (del_hit) begin
                r_used[r_chk_pos] <= 1'b0;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload, probe position and result registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd        <= i_item.command;
            r_val        <= i_item.value;
            r_res_status <= dht_pkg::ST_NOT_FOUND;
            r_res_slot   <= '0;
        end
        if ((r_state == S_HASH) && hash_res.done) begin
            // Delete scans slot 0 upward; the others start at probe one of the sequence.
            if (r_cmd == dht_pkg::CMD_DELETE) begin
                r_pos    <= '0;
                r_stride <= dht_pkg::t_rem'(1);
            end else begin
                r_pos    <= dht_pkg::wrap_slot(dht_pkg::SUM_W'(hash_res.base)
                                             + dht_pkg::SUM_W'(hash_res.stride));
                r_stride <= hash_res.stride;
            end
        end else if (issue) begin
            r_chk_pos <= r_pos;
            r_pos     <= dht_pkg::wrap_slot(dht_pkg::SUM_W'(r_pos) + dht_pkg::SUM_W'(r_stride));
        end
        if (fin) begin
            r_res_status <= fin_status;
            r_res_slot   <= hit ? dht_pkg::IDX_W'(r_chk_pos) : '0;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    // Slot value memory: one read port, one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_pos];
        end
        if (ins_hit) begin
            r_mem[r_chk_pos] <= r_val;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out_status;
    assign o_result.slot_index = r_out_slot;

    `DHT_ASSERT_NOW(a_out_from_done, i_clk, i_rst_n, r_out_valid && !$past(r_out_valid), $past(r_state == S_DONE), "result beat appeared without a finished command")
    `DHT_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != dht_pkg::ST_OK), r_out_slot == '0, "slot index not zero on a failed command")
    `DHT_ASSERT_NOW(a_probe_cap, i_clk, i_rst_n, walk, r_iss_cnt <= dht_pkg::CNT_W'(dht_pkg::TABLE_SIZE), "probe walk ran past the table size")
    `DHT_ASSERT_NEXT(a_insert_marks, i_clk, i_rst_n, ins_hit, r_used[$past(r_chk_pos)], "inserted slot not marked used")

endmodule

`default_nettype wire

FILE: verif/tb_double_hash_table_unit.sv
// Self-checking testbench of double_hash_table_unit: directed and random command beats.
// Depends on dht_pkg and dht_ifs, and on the RTL of the block itself.
// A mirror of the slot table predicts every result beat; both channels idle at random.

module tb_double_hash_table_unit;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 450;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int BASE_MOD      = 13;
    localparam int STRIDE_MOD    = 7;
    localparam int POOL_SIZE     = 16;
    localparam int RECENT_DEPTH  = 32;
    // Values that differ by this amount share both remainders, hence the probe sequence.
    localparam int SAME_SEQ_STEP = BASE_MOD * STRIDE_MOD;

    localparam dht_pkg::t_cmd CMD_UNUSED = 2'd3;

    typedef struct {
        dht_pkg::t_status status;
        dht_pkg::t_index  slot_index;
    } t_outcome;

    // Mirror of the slot table. Every accepted command updates it and queues the
    // outcome it predicts; every result beat is compared with the oldest outcome.
    class hash_table_mirror;
        bit              used[dht_pkg::TABLE_SIZE];
        dht_pkg::t_value stored[dht_pkg::TABLE_SIZE];
        t_outcome        pending[$];
        int              fault_count;
        int              cmd_count[4];
        int              status_count[4];

        function new();
            foreach (used[k]) begin
                used[k]   = 1'b0;
                stored[k] = '0;
            end
            fault_count = 0;
            foreach (cmd_count[k]) begin
                cmd_count[k]    = 0;
                status_count[k] = 0;
            end
        endfunction

        function int probe_position(dht_pkg::t_value v, int probe_no);
            int base_rem;
            int stride;
            base_rem = int'(v) % BASE_MOD;
            stride   = STRIDE_MOD - int'(v) % STRIDE_MOD;
            return (base_rem + probe_no * stride) % dht_pkg::TABLE_SIZE;
        endfunction

        function void note_command(dht_pkg::t_cmd cmd, dht_pkg::t_value v);
            t_outcome o;
            int s;
            o.status     = dht_pkg::ST_NOT_FOUND;
            o.slot_index = '0;
            cmd_count[cmd]++;
            case (cmd)
                dht_pkg::CMD_INSERT: begin
                    o.status = dht_pkg::ST_FULL;
                    for (int probe_no = 1; probe_no <= dht_pkg::TABLE_SIZE; probe_no++) begin
                        s = probe_position(v, probe_no);
                        if (!used[s]) begin
                            used[s]      = 1'b1;
                            stored[s]    = v;
                            o.status     = dht_pkg::ST_OK;
                            o.slot_index = dht_pkg::t_index'(s);
                            break;
                        end
                    end
                end
                dht_pkg::CMD_SEARCH: begin
                    for (int probe_no = 1; probe_no <= dht_pkg::TABLE_SIZE; probe_no++) begin
                        s = probe_position(v, probe_no);
                        if (!used[s]) begin
                            break;
                        end
                        if (stored[s] == v) begin
                            o.status     = dht_pkg::ST_OK;
                            o.slot_index = dht_pkg::t_index'(s);
                            break;
                        end
                    end
                end
                dht_pkg::CMD_DELETE: begin
                    for (int k = 0; k < dht_pkg::TABLE_SIZE; k++) begin
                        if (used[k] && stored[k] == v) begin
                            used[k]      = 1'b0;
                            stored[k]    = '0;
                            o.status     = dht_pkg::ST_OK;
                            o.slot_index = dht_pkg::t_index'(k);
                            break;
                        end
                    end
                end
                default: begin
                end
            endcase
            pending.push_back(o);
        endfunction

        function void check_result(dht_pkg::t_status got_status, dht_pkg::t_index got_slot);
            t_outcome want;
            status_count[got_status]++;
            if (pending.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("[%0t] result beat with nothing pending: status %0d slot %0d",
                             $realtime, got_status, got_slot);
                end
                return;
            end
            want = pending.pop_front();
            if (want.status !== got_status || want.slot_index !== got_slot) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("[%0t] mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                             $realtime, want.status, want.slot_index, got_status, got_slot);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned cycle_count = 0;

    // Testbench-side drivers of the channel signals, known from time zero.
    logic            send_valid = 1'b0;
    dht_pkg::t_cmd   send_cmd   = dht_pkg::CMD_INSERT;
    dht_pkg::t_value send_value = '0;
    logic            take_ready = 1'b0;

    hash_table_mirror mirror = new();

    dht_pkg::t_value recent_values[$];
    dht_pkg::t_value value_pool[POOL_SIZE];
    int              burst_left = 0;

    dht_in_if  item_bus();
    dht_out_if result_bus();

    assign item_bus.valid   = send_valid;
    assign item_bus.command = send_cmd;
    assign item_bus.value   = send_value;
    assign result_bus.ready = take_ready;

    double_hash_table_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, mirror.pending.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side. Beats are checked at the edge that takes them; the stall pattern
    // moves through four phases: always ready, mostly ready, mostly stalled, periodic.
    always @(posedge clk) begin
        if (!rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                mirror.check_result(result_bus.status, result_bus.slot_index);
            end
            case ((cycle_count / 300) % 4)
                0: begin
                    take_ready <= 1'b1;
                end
                1: begin
                    take_ready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    take_ready <= ($urandom_range(0, 9) < 3);
                end
                default: begin
                    take_ready <= ((cycle_count % 11) >= 5);
                end
            endcase
        end
    end

    // The sender runs in bursts of random length and drops valid between bursts,
    // which puts gaps on every phase of the hash and probe walk.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            send_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    // Presents one command beat and waits for the edge that accepts it.
    // Called right after a rising edge.
    task automatic send_beat(dht_pkg::t_cmd cmd, dht_pkg::t_value v, bit allow_gap);
        send_valid <= 1'b1;
        send_cmd   <= cmd;
        send_value <= v;
        do @(posedge clk); while (!item_bus.ready);
        mirror.note_command(cmd, v);
        if (cmd == dht_pkg::CMD_INSERT) begin
            recent_values.push_back(v);
            if (recent_values.size() > RECENT_DEPTH) begin
                void'(recent_values.pop_front());
            end
        end
        if (allow_gap) begin
            pace_sender();
        end
    endtask

    // Half of the pool is fully random; the other half shares one probe sequence,
    // so that searches walk past occupied slots that hold other values.
    task automatic refill_pool();
        int anchor;
        anchor = $urandom_range(0, SAME_SEQ_STEP - 1);
        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k % 2 == 0) begin
                value_pool[k] = dht_pkg::t_value'($urandom);
            end else begin
                value_pool[k] = dht_pkg::t_value'(anchor + SAME_SEQ_STEP * $urandom_range(0, 719));
            end
        end
    endtask

    function automatic dht_pkg::t_value pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && recent_values.size() > 0) begin
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        end else if (r < 90) begin
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return dht_pkg::t_value'($urandom);
    endfunction

    function automatic dht_pkg::t_cmd pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return dht_pkg::CMD_INSERT;
        end else if (r < 70) begin
            return dht_pkg::CMD_SEARCH;
        end else if (r < 96) begin
            return dht_pkg::CMD_DELETE;
        end
        return CMD_UNUSED;
    endfunction

    // Directed opening. The table starts empty; the sequence walks through each
    // corner case and ends with a completely full table.
    task automatic run_directed();
        // Empty table: search and delete miss, zero included.
        send_beat(dht_pkg::CMD_SEARCH, 16'h0000, 1'b1);
        send_beat(dht_pkg::CMD_DELETE, 16'h0000, 1'b1);
        // Field extremes.
        send_beat(dht_pkg::CMD_INSERT, 16'h0000, 1'b1);
        send_beat(dht_pkg::CMD_INSERT, 16'hFFFF, 1'b1);
        send_beat(dht_pkg::CMD_SEARCH, 16'h0000, 1'b1);
        send_beat(dht_pkg::CMD_SEARCH, 16'hFFFF, 1'b1);
        // Value 2 has stride 5, so its walk only ever visits slots 7 and 2, and slot 7
        // already holds zero. The second and third inserts report a full table although
        // most slots are still empty.
        send_beat(dht_pkg::CMD_INSERT, 16'd2, 1'b1);
        send_beat(dht_pkg::CMD_INSERT, 16'd2, 1'b1);
        send_beat(dht_pkg::CMD_INSERT, 16'd2, 1'b1);
        // Same probe sequence as value 2, both slots taken by other values:
        // the search uses up all its probes.
        send_beat(dht_pkg::CMD_SEARCH, 16'd2 + 16'(SAME_SEQ_STEP), 1'b1);
        // Deleting the copy at slot 2 leaves an empty slot in the walk of value 2,
        // so the next search stops there, before it could reach anything further.
        send_beat(dht_pkg::CMD_DELETE, 16'd2, 1'b1);
        send_beat(dht_pkg::CMD_SEARCH, 16'd2, 1'b1);
        // A cleared slot must not match zero.
        send_beat(dht_pkg::CMD_DELETE, 16'h0000, 1'b1);
        send_beat(dht_pkg::CMD_DELETE, 16'h0000, 1'b1);
        // The unused command code changes nothing.
        send_beat(CMD_UNUSED, 16'hFFFF, 1'b1);
        // Multiples of 7 have stride 7, which visits every slot: fill the table,
        // then one more insert finds no room at all.
        for (int k = 1; k <= dht_pkg::TABLE_SIZE - 1; k++) begin
            send_beat(dht_pkg::CMD_INSERT, dht_pkg::t_value'(STRIDE_MOD * 1001 * k), 1'b1);
        end
        send_beat(dht_pkg::CMD_INSERT, dht_pkg::t_value'(STRIDE_MOD * 10), 1'b1);
    endtask

    initial begin
        refill_pool();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random part. A stretch in the middle runs without sender gaps so that
        // back-to-back beats meet a result held in the output register.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 149) begin
                refill_pool();
            end
            send_beat(pick_command(), pick_value(), !(n inside {[150:229]}));
        end
        send_valid <= 1'b0;

        while (mirror.pending.size() > 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command beats: %0d insert, %0d search, %0d delete, %0d unused code.",
                 mirror.cmd_count[0] + mirror.cmd_count[1] + mirror.cmd_count[2]
                     + mirror.cmd_count[3],
                 mirror.cmd_count[dht_pkg::CMD_INSERT], mirror.cmd_count[dht_pkg::CMD_SEARCH],
                 mirror.cmd_count[dht_pkg::CMD_DELETE], mirror.cmd_count[CMD_UNUSED]);
        $display("Results: %0d done or found, %0d not found, %0d table full; %0d faults.",
                 mirror.status_count[dht_pkg::ST_OK], mirror.status_count[dht_pkg::ST_NOT_FOUND],
                 mirror.status_count[dht_pkg::ST_FULL], mirror.fault_count);
        if (mirror.fault_count == 0 && mirror.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/dht_pkg.sv
design/dht_ifs.sv
design/dht_hash.sv
design/double_hash_table_unit.sv
verif/tb_double_hash_table_unit.sv
